### design/adc_code_to_microvolt_scaler_assert.svh
// Assertion macros shared by the scaler's checker.
`ifndef ADC_CODE_TO_MICROVOLT_SCALER_ASSERT_SVH
`define ADC_CODE_TO_MICROVOLT_SCALER_ASSERT_SVH

// Same-cycle implication, masked while reset is low.
`define ACMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low.
`define ACMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/acms_pkg.sv
// Types and constants of the ADC code to microvolt scaler.
`timescale 1ns / 1ps

package acms_pkg;

    localparam int CODE_W     = 16;
    localparam int SPAN_W     = 27;
    localparam int PROD_W     = 43;
    localparam int CFG_W      = 8;
    localparam int RES_W      = 5;
    localparam int MUL_CNT_W  = 5;
    localparam int DIV_CNT_W  = 6;

    localparam logic [MUL_CNT_W-1:0] MUL_STEPS = MUL_CNT_W'(CODE_W);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(PROD_W);

    localparam logic [SPAN_W-1:0] SPAN_WIDE     = 27'd120000000;
    localparam logic [SPAN_W-1:0] SPAN_NARROW   = 27'd20000000;
    localparam logic [31:0]       OFFSET_WIDE   = 32'd60000000;
    localparam logic [31:0]       OFFSET_NARROW = 32'd10000000;

    localparam logic [RES_W-1:0] RES_MIN   = 5'd12;
    localparam logic [RES_W-1:0] RES_MAX   = 5'd16;
    localparam logic [RES_W-1:0] RES_RESET = 5'd12;

    typedef enum logic [1:0] {
        REG_RANGE_MASK  = 2'd0,
        REG_THERM_MASK  = 2'd1,
        REG_RESOLUTION  = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [7:0] code_low;
        logic [7:0] code_high;
        logic       block_end;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] scaled_value;
        logic [2:0]         channel_number;
        logic               thermistor_raw;
    } t_out_word;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

### design/acms_mul.sv
// Bit-serial shift-add multiplier: code times span, one code bit per cycle.
`timescale 1ns / 1ps

module acms_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [acms_pkg::CODE_W-1:0] i_code,
    input  logic [acms_pkg::SPAN_W-1:0] i_span,
    output logic [acms_pkg::PROD_W-1:0] o_product,
    output acms_pkg::t_unit_stat        o_stat
);
    import acms_pkg::*;

    logic [PROD_W-1:0]    r_acc, n_acc;
    logic [CODE_W-1:0]    r_code, n_code;
    logic [SPAN_W-1:0]    r_span;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_code = r_code;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_code = i_code;
            n_cnt  = MUL_STEPS;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // MSB first: double, then add span if the bit is set
            n_acc  = {r_acc[PROD_W-2:0], 1'b0}
                   + (r_code[CODE_W-1] ? {{(PROD_W-SPAN_W){1'b0}}, r_span} : '0);
            n_code = {r_code[CODE_W-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == MUL_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_code <= n_code;
        if (i_start) begin
            r_span <= i_span;
        end
    end

    assign o_product   = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

### design/acms_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module acms_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [acms_pkg::PROD_W-1:0] i_dividend,
    input  logic [acms_pkg::CODE_W-1:0] i_divisor,
    output logic [acms_pkg::PROD_W-1:0] o_quotient,
    output acms_pkg::t_unit_stat        o_stat
);
    import acms_pkg::*;

    logic [CODE_W-1:0]    r_rem, n_rem;
    logic [PROD_W-1:0]    r_quo, n_quo;
    logic [CODE_W-1:0]    r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CODE_W:0]      trial;
    logic [CODE_W:0]      diff;
    logic                 fits;

    // Dividend bits leave r_quo at the top while quotient bits enter at the bottom
    assign trial = {r_rem, r_quo[PROD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign fits  = (trial >= {1'b0, r_dsr});

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = DIV_STEPS;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = fits ? diff[CODE_W-1:0] : trial[CODE_W-1:0];
            n_quo  = {r_quo[PROD_W-2:0], fits};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

### design/adc_code_to_microvolt_scaler.sv
// Top level of the ADC code to microvolt scaler.
`timescale 1ns / 1ps

// Each input word carries one raw ADC code (low byte, high byte) and an end-of-block
// flag, and yields one output word: the channel the sample belonged to, and either
// offset - trunc(code * span / (2^r - 1)) in microvolts, or for a thermistor channel
// the raw code with thermistor_raw set. The channel counter steps 0 to CHANNEL_COUNT-1,
// wraps, and restarts at 0 after a word with block_end set. Resolution writes below 12
// act as 12 and above 16 act as 16. A scaled word is launched into the bit-serial
// shift-add multiplier (16 steps), then goes through the bit-serial restoring divider
// (43 steps, one quotient bit per step), and is then handed off to the output register.
// A thermistor word skips both units. One word is in flight at a time, so the input
// stalls from accept until the word is handed off; the output register lets the next
// word in while a finished one still waits behind a stall. Write configuration only
// while the block is idle.
module adc_code_to_microvolt_scaler #(
    parameter int CHANNEL_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  acms_pkg::t_in_word i_in_word,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output acms_pkg::t_out_word o_out_word,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [acms_pkg::CFG_W-1:0] i_cfg_data
);
    import acms_pkg::*;

    localparam logic [3:0] CH_LIMIT = 4'(CHANNEL_COUNT);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [7:0]       r_range_mask;
    logic [7:0]       r_therm_mask;
    logic [RES_W-1:0] r_resolution;

    // channel counter and per-word context
    logic [2:0]        r_chan, n_chan;
    logic [2:0]        r_word_chan;
    logic              r_word_therm;
    logic              r_word_wide;
    logic [CODE_W-1:0] r_word_code;

    // output register
    t_out_word r_out_word;
    logic      r_out_valid, n_out_valid;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic [CODE_W-1:0] in_code;
    logic              in_therm;
    logic              in_wide;
    logic [RES_W-1:0]  res_clamped;
    logic [CODE_W-1:0] divisor;
    logic [31:0]       offset;
    logic [31:0]       result;
    logic [SPAN_W-1:0] in_span;

    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] quotient;
    t_unit_stat        mul_stat;
    t_unit_stat        div_stat;
    logic              mul_start;

    // ---- input side ----
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_code    = {i_in_word.code_high, i_in_word.code_low};
    assign in_therm   = r_therm_mask[r_chan];
    assign in_wide    = r_range_mask[r_chan];
    assign in_span    = in_wide ? SPAN_WIDE : SPAN_NARROW;

    // Launch the multiplier straight from the accept; thermistor words skip it
    assign mul_start = in_accept && !in_therm;

    // Next channel: wrap at the channel count or restart after the block's last word
    always_comb begin
        n_chan = r_chan;
        if (in_accept) begin
            if (i_in_word.block_end || ({1'b0, r_chan} + 4'd1 >= CH_LIMIT)) begin
                n_chan = '0;
            end else begin
                n_chan = r_chan + 3'd1;
            end
        end
    end

    // ---- divisor: 2^r - 1 with r held inside 12..16 ----
    always_comb begin
        res_clamped = r_resolution;
        if (r_resolution < RES_MIN) begin
            res_clamped = RES_MIN;
        end else if (r_resolution > RES_MAX) begin
            res_clamped = RES_MAX;
        end
    end
    assign divisor = {CODE_W{1'b1}} >> (RES_MAX - res_clamped);

    // ---- serial arithmetic ----
    acms_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_code    (in_code),
        .i_span    (in_span),
        .o_product (product),
        .o_stat    (mul_stat)
    );

    acms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mul_stat.done),
        .i_dividend (product),
        .i_divisor  (divisor),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    // Quotient never exceeds 31 bits for r >= 12, so a 32-bit subtract is exact
    assign offset = r_word_wide ? OFFSET_WIDE : OFFSET_NARROW;
    assign result = r_word_therm ? {16'd0, r_word_code} : (offset - quotient[31:0]);

    // ---- sequencer ----
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_DONE) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = in_therm ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                if (mul_stat.done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold a stalled word; drop it once taken unless a new one replaces it
    assign n_out_valid = out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chan       <= '0;
            r_out_valid  <= 1'b0;
            r_range_mask <= '0;
            r_therm_mask <= '0;
            r_resolution <= RES_RESET;
        end else begin
            r_state     <= n_state;
            r_chan      <= n_chan;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RANGE_MASK: r_range_mask <= i_cfg_data;
                    REG_THERM_MASK: r_therm_mask <= i_cfg_data;
                    REG_RESOLUTION: r_resolution <= i_cfg_data[RES_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Capture the word's context at accept, the result at hand-off
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_word_chan  <= r_chan;
            r_word_therm <= in_therm;
            r_word_wide  <= in_wide;
            r_word_code  <= in_code;
        end
        if (out_load) begin
            r_out_word.scaled_value   <= $signed(result);
            r_out_word.channel_number <= r_word_chan;
            r_out_word.thermistor_raw <= r_word_therm;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### design/acms_checker.sv
// Port-level checker for the ADC code to microvolt scaler, bound to the top level.
`timescale 1ns / 1ps
`include "adc_code_to_microvolt_scaler_assert.svh"

module acms_checker #(
    parameter int CHANNEL_COUNT = 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input acms_pkg::t_out_word   o_out_word
);
    import acms_pkg::*;

    localparam logic [3:0] CH_LIMIT = 4'(CHANNEL_COUNT);

    logic        out_wait;
    logic        raw_out;
    logic        scaled_out;
    logic [15:0] raw_top;
    logic        chan_ok;
    logic        below_max;

    assign out_wait   = o_out_valid && i_out_stall;
    assign raw_out    = o_out_valid && o_out_word.thermistor_raw;
    assign scaled_out = o_out_valid && !o_out_word.thermistor_raw;
    assign raw_top    = o_out_word.scaled_value[31:16];
    assign chan_ok    = ({1'b0, o_out_word.channel_number} < CH_LIMIT);
    assign below_max  = (o_out_word.scaled_value <= $signed(OFFSET_WIDE));

    // A stalled output word stays offered and unchanged
    `ACMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid, "stalled word dropped")
    `ACMS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_wait, $stable(o_out_word), "stalled word changed")

    // Raw thermistor codes are only 16 bits wide
    `ACMS_ASSERT_NOW(a_therm_width, i_clk, i_rst_n, raw_out, raw_top == '0, "raw code too wide")

    // Channel number stays below the channel count
    `ACMS_ASSERT_NOW(a_chan_range, i_clk, i_rst_n, o_out_valid, chan_ok, "channel out of range")

    // A scaled value never exceeds the wide offset
    `ACMS_ASSERT_NOW(a_scaled_max, i_clk, i_rst_n, scaled_out, below_max, "scaled value above offset")

endmodule

bind adc_code_to_microvolt_scaler acms_checker #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
) u_acms_checker (.*);
